// ----- design/hssp_pkg.sv -----
`default_nettype none

package hssp_pkg;

    // Default revolution length in half-steps
    localparam int unsigned STEPS_PER_TURN = 4096;

    // Field widths fixed by the item format
    localparam int unsigned VAL_W = 24;
    localparam int unsigned TICK_W = 24;
    localparam int unsigned POS_OUT_W = 12;
    localparam int unsigned COIL_W = 4;

    localparam logic [TICK_W-1:0] INTERVAL_RST = 24'd2500;
    localparam logic [TICK_W-1:0] TICK_MAX = 24'hFFFFFF;

    // Item kind carried on the input tuser
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_MOVE_ABS = 2'd1,
        CMD_MOVE_REL = 2'd2,
        CMD_HOME     = 2'd3
    } t_cmd;

    // Motion state
    typedef enum logic [1:0] {
        MOT_IDLE   = 2'd0,
        MOT_MOVING = 2'd1,
        MOT_HOMING = 2'd2
    } t_motion;

    // Control travelling alongside the reduced value
    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic endstop;
    } t_ctl;

    // Half-step coil sequence, bit3 is the first coil
    function automatic logic [COIL_W-1:0] coil_of(input logic [2:0] phase);
        logic [COIL_W-1:0] c;
        case (phase)
            3'd0: c = 4'h8;
            3'd1: c = 4'hC;
            3'd2: c = 4'h4;
            3'd3: c = 4'h6;
            3'd4: c = 4'h2;
            3'd5: c = 4'h3;
            3'd6: c = 4'h1;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/hssp_modred.sv -----
`default_nettype none

// Three-stage reduction of the signed value modulo the revolution length.
// Result is left in [0, 2*P_STEPS); the final compare-subtract is done by the core.
module hssp_modred import hssp_pkg::*; #(
    parameter int unsigned P_STEPS = STEPS_PER_TURN,
    localparam int unsigned RW = $clog2(2 * P_STEPS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire t_cmd             i_cmd,
    input  wire logic [VAL_W-1:0] i_val,
    input  wire logic             i_endstop,
    output t_ctl                  o_ctl,
    output logic [RW-1:0]         o_rem
);

    localparam int unsigned UW = VAL_W + 1;
    localparam int unsigned SH = UW;
    localparam int unsigned MUL = (1 << SH) / P_STEPS;
    localparam int unsigned OFFS = (((1 << (VAL_W - 1)) + P_STEPS - 1) / P_STEPS) * P_STEPS;
    localparam int unsigned MW = $clog2(MUL + 1);
    localparam int unsigned SW = $clog2(P_STEPS + 1);
    localparam int unsigned PW = UW + MW;
    localparam int unsigned QW = MW + SW;

    // Stage 1: input register
    logic             r1_vld;
    t_cmd             r1_cmd;
    logic             r1_end;
    logic [VAL_W-1:0] r1_val;

    // Stage 2: offset value and reciprocal product
    logic             r2_vld;
    t_cmd             r2_cmd;
    logic             r2_end;
    logic [UW-1:0]    r2_u;
    logic [PW-1:0]    r2_prod;

    // Stage 3: remainder before correction
    logic             r3_vld;
    t_cmd             r3_cmd;
    logic             r3_end;
    logic [RW-1:0]    r3_rem;

    logic [UW-1:0]    n_u;
    logic [PW-1:0]    n_prod;
    logic [MW-1:0]    w_quot;
    logic [QW-1:0]    w_qs;
    logic [UW-1:0]    w_diff;

    // Shift the value to nonnegative by a multiple of P_STEPS
    assign n_u = {r1_val[VAL_W-1], r1_val} + UW'(OFFS);
    assign n_prod = PW'(n_u) * PW'(MUL);

    // Quotient estimate is exact or one low
    assign w_quot = r2_prod[PW-1:SH];
    assign w_qs = QW'(w_quot) * QW'(P_STEPS);
    assign w_diff = r2_u - UW'(w_qs);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_cmd  <= i_cmd;
            r1_end  <= i_endstop;
            r1_val  <= i_val;
            r2_cmd  <= r1_cmd;
            r2_end  <= r1_end;
            r2_u    <= n_u;
            r2_prod <= n_prod;
            r3_cmd  <= r2_cmd;
            r3_end  <= r2_end;
            r3_rem  <= w_diff[RW-1:0];
        end
    end

    assign o_ctl = '{valid: r3_vld, cmd: r3_cmd, endstop: r3_end};
    assign o_rem = r3_rem;

endmodule

`default_nettype wire

// ----- design/hssp_core.sv -----
`default_nettype none

// Motion state, step timer and result register.
module hssp_core import hssp_pkg::*; #(
    parameter int unsigned P_STEPS = STEPS_PER_TURN,
    localparam int unsigned RW = $clog2(2 * P_STEPS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire t_ctl              i_ctl,
    input  wire logic [RW-1:0]     i_rem,
    input  wire logic [TICK_W-1:0] i_interval,
    output logic                   o_valid,
    output logic [COIL_W-1:0]      o_coil,
    output logic [POS_OUT_W-1:0]   o_pos,
    output logic                   o_busy,
    output logic                   o_homed,
    output logic                   o_step,
    output logic                   o_failed
);

    localparam int unsigned PSW = $clog2(P_STEPS);
    localparam int unsigned HW = $clog2(3 * P_STEPS + 2);

    t_motion           r_motion, n_motion;
    logic [PSW-1:0]    r_cur, n_cur;
    logic [PSW-1:0]    r_tgt, n_tgt;
    logic [2:0]        r_phase, n_phase;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic              r_homed, n_homed;
    logic [HW-1:0]     r_hcnt, n_hcnt;
    logic              n_step, n_failed;

    logic              r_valid;
    logic [COIL_W-1:0] r_coil;
    logic [PSW-1:0]    r_pos;
    logic              r_busy, r_step, r_failed;

    logic [PSW-1:0]    w_vmod;
    logic [PSW:0]      w_rel_sum;
    logic [PSW-1:0]    w_rel;
    logic [PSW:0]      w_cw_sum;
    logic [PSW-1:0]    w_cw_pos, w_ccw_pos;
    logic [TICK_W-1:0] w_einc;
    logic              w_fire;
    logic [HW-1:0]     w_hinc;

    // Final correction of the reduced value, then relative target
    always_comb begin
        w_vmod = (i_rem >= RW'(P_STEPS)) ? PSW'(i_rem - RW'(P_STEPS)) : PSW'(i_rem);
        w_rel_sum = {1'b0, r_cur} + {1'b0, w_vmod};
        w_rel = (w_rel_sum >= (PSW+1)'(P_STEPS)) ? PSW'(w_rel_sum - (PSW+1)'(P_STEPS))
                                                 : w_rel_sum[PSW-1:0];
    end

    // Neighbor positions and timer
    always_comb begin
        w_cw_sum = {1'b0, r_cur} + (PSW+1)'(1);
        w_cw_pos = (w_cw_sum >= (PSW+1)'(P_STEPS)) ? '0 : w_cw_sum[PSW-1:0];
        w_ccw_pos = (r_cur == '0) ? PSW'(P_STEPS - 1) : r_cur - PSW'(1);
        w_einc = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + TICK_W'(1);
        w_fire = (i_interval != '0) && (w_einc >= i_interval);
        w_hinc = r_hcnt + HW'(1);
    end

    // Next state
    always_comb begin
        n_motion  = r_motion;
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_homed   = r_homed;
        n_hcnt    = r_hcnt;
        n_step    = 1'b0;
        n_failed  = 1'b0;
        if (i_ctl.valid) begin
            unique case (i_ctl.cmd)
                CMD_MOVE_ABS: begin
                    n_tgt    = w_vmod;
                    n_motion = MOT_MOVING;
                end
                CMD_MOVE_REL: begin
                    n_tgt    = w_rel;
                    n_motion = MOT_MOVING;
                end
                CMD_HOME: begin
                    n_motion = MOT_HOMING;
                    n_homed  = 1'b0;
                end
                default: begin
                    n_elapsed = w_einc;
                    if (w_fire) begin
                        n_elapsed = '0;
                        unique case (r_motion)
                            MOT_MOVING: begin
                                if (r_cur == r_tgt) begin
                                    n_motion = MOT_IDLE;
                                end else if (r_tgt > r_cur) begin
                                    n_cur   = w_cw_pos;
                                    n_phase = r_phase + 3'd1;
                                    n_step  = 1'b1;
                                end else begin
                                    n_cur   = w_ccw_pos;
                                    n_phase = r_phase - 3'd1;
                                    n_step  = 1'b1;
                                end
                            end
                            MOT_HOMING: begin
                                n_cur   = w_ccw_pos;
                                n_phase = r_phase - 3'd1;
                                n_step  = 1'b1;
                                n_hcnt  = w_hinc;
                                // abort check wins over the endstop
                                if (w_hinc > HW'(3 * P_STEPS)) begin
                                    n_motion = MOT_IDLE;
                                    n_hcnt   = '0;
                                    n_failed = 1'b1;
                                end else if (!i_ctl.endstop) begin
                                    n_cur    = '0;
                                    n_tgt    = '0;
                                    n_homed  = 1'b1;
                                    n_motion = MOT_IDLE;
                                    n_hcnt   = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion <= MOT_IDLE;
        end else if (i_adv) begin
            r_motion <= n_motion;
        end
    end

    // Position, timer and homing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_tgt     <= '0;
            r_phase   <= '0;
            r_elapsed <= '0;
            r_homed   <= 1'b0;
            r_hcnt    <= '0;
            r_valid   <= 1'b0;
        end else if (i_adv) begin
            r_cur     <= n_cur;
            r_tgt     <= n_tgt;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_homed   <= n_homed;
            r_hcnt    <= n_hcnt;
            r_valid   <= i_ctl.valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_coil   <= coil_of(n_phase);
            r_pos    <= n_cur;
            r_busy   <= (n_motion != MOT_IDLE);
            r_step   <= n_step;
            r_failed <= n_failed;
        end
    end

    assign o_valid  = r_valid;
    assign o_coil   = r_coil;
    assign o_pos    = POS_OUT_W'(r_pos);
    assign o_busy   = r_busy;
    assign o_homed  = r_homed;
    assign o_step   = r_step;
    assign o_failed = r_failed;

endmodule

`default_nettype wire

// ----- design/half_step_stepper_positioner.sv -----
// Half-step stepper positioner.
// An accepted item passes through the input register, reciprocal multiply, remainder
// multiply and state/result register, in that order, before its result is valid.
// Throughput: one item per cycle; the whole pipeline stalls only when a result waits.
// Reset (synchronous, active low): position, target, phase, timer and homing state
// cleared, motion idle, step interval set to 2500.
`default_nettype none

module half_step_stepper_positioner import hssp_pkg::*; #(
    parameter int unsigned P_STEPS = STEPS_PER_TURN
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input item
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [31:0]       s_axis_tdata,  // target_value[23:0], endstop_level[24]
    input  wire logic [1:0]        s_axis_tuser,  // mode[1:0]
    // result item
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [23:0]            m_axis_tdata,  // coil_pattern[3:0], position[15:4],
                                                  // busy_res[16], is_homed[17],
                                                  // step_taken[18], homing_failed[19]
    // step interval register
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [TICK_W-1:0] i_cfg_data
);

    localparam int unsigned RW = $clog2(2 * P_STEPS);

    logic [TICK_W-1:0]     r_step_interval;
    logic                  w_adv;
    t_ctl                  w_ctl;
    logic [RW-1:0]         w_rem;
    logic [COIL_W-1:0]     w_coil;
    logic [POS_OUT_W-1:0]  w_pos;
    logic                  w_busy, w_homed, w_step, w_failed;

    // Pipeline moves unless a finished result is held
    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign o_cfg_ready = 1'b1;

    // Step interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval <= INTERVAL_RST;
        end else if (i_cfg_valid) begin
            r_step_interval <= i_cfg_data;
        end
    end

    hssp_modred #(
        .P_STEPS (P_STEPS)
    ) u_modred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (s_axis_tvalid),
        .i_cmd     (t_cmd'(s_axis_tuser)),
        .i_val     (s_axis_tdata[VAL_W-1:0]),
        .i_endstop (s_axis_tdata[VAL_W]),
        .o_ctl     (w_ctl),
        .o_rem     (w_rem)
    );

    hssp_core #(
        .P_STEPS (P_STEPS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_ctl      (w_ctl),
        .i_rem      (w_rem),
        .i_interval (r_step_interval),
        .o_valid    (m_axis_tvalid),
        .o_coil     (w_coil),
        .o_pos      (w_pos),
        .o_busy     (w_busy),
        .o_homed    (w_homed),
        .o_step     (w_step),
        .o_failed   (w_failed)
    );

    // Pack the result item
    assign m_axis_tdata = {4'b0000, w_failed, w_step, w_homed, w_busy, w_pos, w_coil};

endmodule

`default_nettype wire

// ----- test/tb_half_step_stepper_positioner.sv -----
`timescale 1ns / 1ps

module tb_half_step_stepper_positioner;
    import hssp_pkg::*;

    localparam int REV         = STEPS_PER_TURN;
    localparam int HOME_LIMIT  = 3 * REV;
    localparam int SETTLE      = 4;        // pipeline depth plus margin
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 210;

    // coil nibble per phase, phase 0 in the low nibble
    localparam logic [31:0] COIL_SEQ = 32'h9132_64C8;

    // result fields, lowest bit last
    typedef struct packed {
        logic        failed;
        logic        stepped;
        logic        homed;
        logic        busy;
        logic [11:0] pos;
        logic [3:0]  coil;
    } motor_out_t;

    // one row of the directed plan: either an interval write or an item
    typedef struct {
        bit          is_cfg;
        logic [23:0] cfg_val;
        t_cmd        cmd;
        logic [23:0] val;
        logic        es;
        bit          pinned;
        motor_out_t  fixed;
    } drive_row_t;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [23:0] cfg_data  = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic        o_cfg_ready;

    // motor state as the block should hold it
    logic [23:0] interval   = INTERVAL_RST;
    logic [11:0] pos_now    = '0;
    logic [11:0] pos_goal   = '0;
    logic [2:0]  phase      = '0;
    t_motion     motion     = MOT_IDLE;
    logic [23:0] tick_count = '0;
    logic        homed      = 1'b0;
    int          home_steps = 0;

    motor_out_t  due_outputs[$];
    drive_row_t  plan[$];

    int  items_sent   = 0;
    int  results_seen = 0;
    int  err_count    = 0;
    int  steps_made   = 0;
    int  homes_ok     = 0;
    int  home_aborts  = 0;
    int  cycles       = 0;
    bit  gaps_on      = 1'b1;
    bit  hold_request = 1'b0;

    half_step_stepper_positioner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [11:0] wrap_rev(input int v);
        int r;
        r = v % REV;
        if (r < 0) r += REV;
        return 12'(r);
    endfunction

    // one half-step, phase and position move together
    function automatic void half_step(input bit cw);
        if (cw) begin
            phase   = phase + 3'd1;
            pos_now = (pos_now == 12'(REV - 1)) ? 12'd0 : pos_now + 12'd1;
        end else begin
            phase   = phase - 3'd1;
            pos_now = (pos_now == 12'd0) ? 12'(REV - 1) : pos_now - 12'd1;
        end
    endfunction

    // apply one accepted item to the motor state and return the output it should give
    function automatic motor_out_t advance_motor(input t_cmd cmd, input logic [23:0] val,
                                                 input logic es);
        motor_out_t r;
        r = '0;
        case (cmd)
            CMD_MOVE_ABS: begin
                pos_goal = wrap_rev(int'($signed(val)));
                motion   = MOT_MOVING;
            end
            CMD_MOVE_REL: begin
                pos_goal = wrap_rev(int'(pos_now) + int'($signed(val)));
                motion   = MOT_MOVING;
            end
            CMD_HOME: begin
                motion = MOT_HOMING;
                homed  = 1'b0;
            end
            default: begin
                if (tick_count != TICK_MAX) tick_count = tick_count + 24'd1;
                if (interval != 0 && tick_count >= interval) begin
                    tick_count = '0;
                    if (motion == MOT_MOVING) begin
                        if (pos_now == pos_goal) begin
                            motion = MOT_IDLE;
                        end else begin
                            half_step(pos_goal > pos_now);
                            r.stepped = 1'b1;
                        end
                    end else if (motion == MOT_HOMING) begin
                        half_step(1'b0);
                        r.stepped  = 1'b1;
                        home_steps = home_steps + 1;
                        // run-length limit wins over the endstop
                        if (home_steps > HOME_LIMIT) begin
                            motion     = MOT_IDLE;
                            home_steps = 0;
                            r.failed   = 1'b1;
                            home_aborts++;
                        end else if (!es) begin
                            pos_now    = '0;
                            pos_goal   = '0;
                            homed      = 1'b1;
                            motion     = MOT_IDLE;
                            home_steps = 0;
                            homes_ok++;
                        end
                    end
                end
            end
        endcase
        if (r.stepped) steps_made++;
        r.coil  = COIL_SEQ[4*phase +: 4];
        r.pos   = pos_now;
        r.busy  = (motion != MOT_IDLE);
        r.homed = homed;
        return r;
    endfunction

    function automatic drive_row_t item_row(input t_cmd cmd, input logic [23:0] val,
                                            input logic es);
        drive_row_t row;
        row = '{is_cfg: 1'b0, cfg_val: '0, cmd: cmd, val: val, es: es,
                pinned: 1'b0, fixed: '0};
        return row;
    endfunction

    function automatic drive_row_t pinned_row(input t_cmd cmd, input logic [23:0] val,
                                              input logic es, input logic [3:0] coil,
                                              input logic [11:0] pos, input logic busy,
                                              input logic hm, input logic stp,
                                              input logic fl);
        drive_row_t row;
        row        = item_row(cmd, val, es);
        row.pinned = 1'b1;
        row.fixed  = {fl, stp, hm, busy, pos, coil};
        return row;
    endfunction

    function automatic drive_row_t cfg_row(input logic [23:0] v);
        drive_row_t row;
        row         = item_row(CMD_TICK, '0, 1'b1);
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    // offer one item, wait for the handshake, then queue its output
    task automatic send_item(input t_cmd cmd, input logic [23:0] val, input logic es,
                             input bit pinned, input motor_out_t fixed);
        motor_out_t model;
        if (gaps_on && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, es, val};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model = advance_motor(cmd, val, es);
        due_outputs.push_back(pinned ? fixed : model);
        items_sent++;
    endtask

    // stop offering and let every queued output come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [23:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        interval = v;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // a command followed by a run of ticks; now and then a stray item of any kind
    task automatic random_burst();
        int          pick;
        int          d;
        int          n;
        logic [23:0] v;
        pick = $urandom_range(0, 99);
        v    = 24'($urandom());
        d    = $urandom_range(0, 60);
        d    = d - 30;
        if (pick < 35) begin
            if ($urandom_range(0, 3) != 0) v = 24'(int'(pos_now) + d);
            send_item(CMD_MOVE_ABS, v, 1'($urandom()), 1'b0, '0);
        end else if (pick < 68) begin
            if ($urandom_range(0, 3) != 0) v = 24'(d);
            send_item(CMD_MOVE_REL, v, 1'($urandom()), 1'b0, '0);
        end else if (pick < 88) begin
            send_item(CMD_HOME, v, 1'($urandom()), 1'b0, '0);
        end else begin
            send_item(t_cmd'(2'($urandom())), v, 1'($urandom()), 1'b0, '0);
        end
        n = $urandom_range(1, 60);
        // endstop rarely pressed while homing so runs get some length
        repeat (n)
            send_item(CMD_TICK, 24'($urandom()),
                      $urandom_range(0, 99) >= (motion == MOT_HOMING ? 3 : 50),
                      1'b0, '0);
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // output checker
    initial begin : result_check
        motor_out_t got;
        motor_out_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_tready) begin
                got = motor_out_t'(m_axis_tdata[19:0]);
                results_seen++;
                if (due_outputs.size() == 0) begin
                    flag_error($sformatf("unexpected output item %h", m_axis_tdata));
                end else begin
                    want = due_outputs.pop_front();
                    if (got.coil !== want.coil || got.pos !== want.pos ||
                        got.busy !== want.busy || got.homed !== want.homed ||
                        got.stepped !== want.stepped || got.failed !== want.failed)
                        flag_error($sformatf(
                            {"output %0d: exp coil %h pos %0d busy %b homed %b step %b fail %b",
                             " / got coil %h pos %0d busy %b homed %b step %b fail %b"},
                            results_seen, want.coil, want.pos, want.busy, want.homed,
                            want.stepped, want.failed, got.coil, got.pos, got.busy,
                            got.homed, got.stepped, got.failed));
                end
            end
        end
    end

    // output backpressure, with one long hold on request
    initial begin : sink_ready
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 15);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d items sent, %0d outputs pending",
                 cycles, items_sent, due_outputs.size());
        $display("half_step_stepper_positioner regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [23:0] rate_plan [RAND_PHASES];
        logic [23:0] rate;
        int          start;
        int          directed_items;
        bit          held;

        rate_plan = '{24'd1, 24'd2, 24'd3, 24'd0, 24'hFFFFFF, 24'd0, 24'd1, 24'd4};
        held      = 1'b0;

        // directed plan: reset outputs, field extremes, every command, halted and
        // slowest timer, homing interrupted by a move, ccw travel the long way round
        plan.push_back(pinned_row(CMD_TICK, 24'h000000, 1'b1, 4'h8, 12'd0, 0, 0, 0, 0));
        plan.push_back(pinned_row(CMD_TICK, 24'hFFFFFF, 1'b0, 4'h8, 12'd0, 0, 0, 0, 0));
        plan.push_back(pinned_row(CMD_MOVE_ABS, 24'h7FFFFF, 1'b1, 4'h8, 12'd0, 1, 0, 0, 0));
        plan.push_back(pinned_row(CMD_MOVE_REL, 24'h800000, 1'b0, 4'h8, 12'd0, 1, 0, 0, 0));
        plan.push_back(pinned_row(CMD_HOME, 24'h000000, 1'b1, 4'h8, 12'd0, 1, 0, 0, 0));
        plan.push_back(cfg_row(24'd1));
        plan.push_back(pinned_row(CMD_TICK, 24'h555555, 1'b1, 4'h9, 12'd4095, 1, 0, 1, 0));
        plan.push_back(pinned_row(CMD_TICK, 24'hAAAAAA, 1'b1, 4'h1, 12'd4094, 1, 0, 1, 0));
        plan.push_back(item_row(CMD_MOVE_REL, 24'd3, 1'b1));
        plan.push_back(item_row(CMD_TICK, 24'd0, 1'b1));
        plan.push_back(item_row(CMD_HOME, 24'd0, 1'b1));
        plan.push_back(item_row(CMD_TICK, 24'd0, 1'b0));
        plan.push_back(item_row(CMD_MOVE_ABS, 24'd3, 1'b1));
        repeat (4) plan.push_back(item_row(CMD_TICK, 24'd0, 1'b1));
        plan.push_back(item_row(CMD_MOVE_REL, 24'hFFFFFE, 1'b1));
        plan.push_back(item_row(CMD_TICK, 24'd0, 1'b1));
        plan.push_back(cfg_row(24'd0));
        plan.push_back(item_row(CMD_MOVE_ABS, 24'd2000, 1'b1));
        repeat (2) plan.push_back(item_row(CMD_TICK, 24'd0, 1'b1));
        plan.push_back(cfg_row(24'hFFFFFF));
        plan.push_back(item_row(CMD_TICK, 24'd0, 1'b1));
        plan.push_back(cfg_row(24'd2));
        repeat (2) plan.push_back(item_row(CMD_TICK, 24'd0, 1'b1));
        plan.push_back(item_row(CMD_MOVE_ABS, 24'hFFFFFF, 1'b1));
        plan.push_back(item_row(CMD_TICK, 24'd0, 1'b1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg)
                write_interval(plan[k].cfg_val);
            else
                send_item(plan[k].cmd, plan[k].val, plan[k].es, plan[k].pinned,
                          plan[k].fixed);
        end
        directed_items = items_sent;

        // random phases, each at its own step interval
        for (int p = 0; p < RAND_PHASES; p++) begin
            rate = (p == 5) ? 24'($urandom_range(1, 6)) : rate_plan[p];
            write_interval(rate);
            gaps_on = (p != 2);
            start   = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if (p == 1 && !held && items_sent - start > 60) begin
                    hold_request = 1'b1;
                    held         = 1'b1;
                end
                random_burst();
            end
        end
        gaps_on = 1'b1;

        write_interval(INTERVAL_RST);
        repeat (3) random_burst();
        drain();

        $display("ran %0d items (%0d directed), %0d outputs checked; step interval at 0, 1..6,",
                 items_sent, directed_items, results_seen);
        $display("  reset value and max; %0d half-steps, %0d homes found, %0d homing aborts",
                 steps_made, homes_ok, home_aborts);
        if (err_count == 0 && due_outputs.size() == 0)
            $display("half_step_stepper_positioner regression: pass");
        else
            $display("half_step_stepper_positioner regression: fail");
        $finish;
    end

endmodule

// ----- half_step_stepper_positioner.f -----
design/hssp_pkg.sv
design/hssp_modred.sv
design/hssp_core.sv
design/half_step_stepper_positioner.sv
test/tb_half_step_stepper_positioner.sv
